// ===== rtl/core/stippled_line_stepper_unit_defines.svh =====
// Assertion macros for the stippled line stepper.
`ifndef STIPPLED_LINE_STEPPER_UNIT_DEFINES_SVH
`define STIPPLED_LINE_STEPPER_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define SLSU_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SLSU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/slsu_pkg.sv =====
// Shared constants, codes and status types of the stippled line stepper.
package slsu_pkg;

  localparam int unsigned COORD_BITS  = 10;
  localparam int unsigned PATTERN_LEN = 8;
  localparam int unsigned COLOR_BITS  = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    ModeStart = 1'b0,
    ModeStep  = 1'b1
  } mode_e;

  // step direction along one axis
  typedef enum logic [1:0] {
    SignNone  = 2'b00,
    SignPlus  = 2'b01,
    SignMinus = 2'b11
  } sign_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic step_push;
  } fe_status_t;

endpackage

// ===== rtl/core/slsu_ifs.sv =====
// Request and pixel channel interfaces of the stippled line stepper.
interface slsu_in_if #(
  parameter int unsigned CoordBits = slsu_pkg::COORD_BITS
) ();
  logic                                    valid;
  logic                                    ready;
  logic                                    mode;
  logic [CoordBits-1:0]                    start_x;
  logic [CoordBits-1:0]                    start_y;
  logic [CoordBits-1:0]                    end_x;
  logic [CoordBits-1:0]                    end_y;
  logic [slsu_pkg::PATTERN_LEN-1:0]        stipple;
  logic [slsu_pkg::COLOR_BITS-1:0]         color_index;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, stipple, color_index,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, stipple, color_index,
                  output ready);
endinterface

interface slsu_out_if #(
  parameter int unsigned CoordBits = slsu_pkg::COORD_BITS
) ();
  logic                            valid;
  logic                            ready;
  logic [CoordBits-1:0]            pixel_x;
  logic [CoordBits-1:0]            pixel_y;
  logic                            plot;
  logic [slsu_pkg::COLOR_BITS-1:0] pixel_color;
  logic                            last;

  modport source (output valid, pixel_x, pixel_y, plot, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, plot, pixel_color, last, output ready);
endinterface

// ===== rtl/core/slsu_queue.sv =====
// Small FIFO of commands between the front and back halves.
module slsu_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = slsu_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [Width-1:0]    data_i,
  input  logic                pop_i,
  output logic [Width-1:0]    data_o,
  output slsu_pkg::q_status_t status_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == CntBits'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/slsu_front.sv =====
// Front half: takes requests, does the line setup and tracks the pixel count.
module slsu_front #(
  parameter int unsigned CoordBits = slsu_pkg::COORD_BITS,
  parameter int unsigned CmdWidth  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  slsu_in_if.sink              req_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output logic [CmdWidth-1:0]  cmd_o,
  output slsu_pkg::fe_status_t status_o
);

  typedef struct packed {
    logic                            is_start;
    logic                            last;
    logic [CoordBits-1:0]            x;
    logic [CoordBits-1:0]            y;
    logic [CoordBits-1:0]            abs_dx;
    logic [CoordBits-1:0]            abs_dy;
    slsu_pkg::sign_e                 sign_x;
    slsu_pkg::sign_e                 sign_y;
    logic                            x_major;
    logic [CoordBits:0]              err;
    logic [slsu_pkg::PATTERN_LEN-1:0] pattern;
    logic [slsu_pkg::COLOR_BITS-1:0] color;
  } cmd_t;

  cmd_t                 cmd;
  logic                 busy_q, busy_d;
  logic [CoordBits:0]   rem_q, rem_d;
  logic                 accept, is_start, step_ok;
  logic [CoordBits-1:0] abs_dx, abs_dy, major_len;
  slsu_pkg::sign_e      sign_x, sign_y;
  logic                 x_major;

  always_comb begin
    if (req_i.end_x > req_i.start_x) begin
      abs_dx = req_i.end_x - req_i.start_x;
      sign_x = slsu_pkg::SignPlus;
    end else if (req_i.start_x > req_i.end_x) begin
      abs_dx = req_i.start_x - req_i.end_x;
      sign_x = slsu_pkg::SignMinus;
    end else begin
      abs_dx = '0;
      sign_x = slsu_pkg::SignNone;
    end
    if (req_i.end_y > req_i.start_y) begin
      abs_dy = req_i.end_y - req_i.start_y;
      sign_y = slsu_pkg::SignPlus;
    end else if (req_i.start_y > req_i.end_y) begin
      abs_dy = req_i.start_y - req_i.end_y;
      sign_y = slsu_pkg::SignMinus;
    end else begin
      abs_dy = '0;
      sign_y = slsu_pkg::SignNone;
    end
  end

  assign x_major   = (abs_dx >= abs_dy);
  assign major_len = x_major ? abs_dx : abs_dy;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && !q_full_i;
  assign is_start    = (req_i.mode == slsu_pkg::ModeStart);
  assign step_ok     = accept && !is_start && busy_q;

  // line length bookkeeping: steps while idle are dropped here
  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    if (accept && is_start) begin
      busy_d = 1'b1;
      rem_d  = {1'b0, major_len} + (CoordBits+1)'(1);
    end else if (step_ok) begin
      rem_d  = rem_q - (CoordBits+1)'(1);
      busy_d = (rem_d != '0);
    end
  end

  always_comb begin
    cmd.is_start = is_start;
    cmd.last     = (rem_d == '0);
    cmd.x        = req_i.start_x;
    cmd.y        = req_i.start_y;
    cmd.abs_dx   = abs_dx;
    cmd.abs_dy   = abs_dy;
    cmd.sign_x   = sign_x;
    cmd.sign_y   = sign_y;
    cmd.x_major  = x_major;
    cmd.err      = {1'b0, major_len} >> 1;
    cmd.pattern  = req_i.stipple;
    cmd.color    = req_i.color_index;
  end

  assign push_o             = accept && (is_start || busy_q);
  assign cmd_o              = CmdWidth'(cmd);
  assign status_o.busy      = busy_q;
  assign status_o.step_push = step_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

endmodule

// ===== rtl/core/slsu_back.sv =====
// Back half: walks the line one pixel per step command and holds the pixel register.
module slsu_back #(
  parameter int unsigned CoordBits = slsu_pkg::COORD_BITS,
  parameter int unsigned CmdWidth  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CmdWidth-1:0] cmd_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  slsu_out_if.source          pix_o
);

  typedef struct packed {
    logic                            is_start;
    logic                            last;
    logic [CoordBits-1:0]            x;
    logic [CoordBits-1:0]            y;
    logic [CoordBits-1:0]            abs_dx;
    logic [CoordBits-1:0]            abs_dy;
    slsu_pkg::sign_e                 sign_x;
    slsu_pkg::sign_e                 sign_y;
    logic                            x_major;
    logic [CoordBits:0]              err;
    logic [slsu_pkg::PATTERN_LEN-1:0] pattern;
    logic [slsu_pkg::COLOR_BITS-1:0] color;
  } cmd_t;

  localparam int unsigned SelBits = $clog2(slsu_pkg::PATTERN_LEN);

  function automatic logic [CoordBits-1:0] step_coord(input logic [CoordBits-1:0] v,
                                                      input slsu_pkg::sign_e s);
    case (s)
      slsu_pkg::SignPlus:  step_coord = v + CoordBits'(1);
      slsu_pkg::SignMinus: step_coord = v - CoordBits'(1);
      default:             step_coord = v;
    endcase
  endfunction

  cmd_t                 cmd;
  logic [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d, abs_dx_q, abs_dy_q;
  logic [CoordBits-1:0] major_len, minor_len, mid_x, mid_y, major_pos;
  logic [CoordBits:0]   err_q, err_d, err_sum;
  slsu_pkg::sign_e      sign_x_q, sign_y_q;
  logic                 x_major_q;
  logic [slsu_pkg::PATTERN_LEN-1:0] pattern_q;
  logic [slsu_pkg::COLOR_BITS-1:0]  color_q;
  logic                 out_valid_q, out_free, do_step, take_minor;

  assign cmd      = cmd_t'(cmd_i);
  assign out_free = !out_valid_q || pix_o.ready;
  assign pop_o    = !q_empty_i && (cmd.is_start || out_free);
  assign do_step  = pop_o && !cmd.is_start;

  // minor axis moves first, then the pixel is taken, then the major axis moves
  always_comb begin
    major_len  = x_major_q ? abs_dx_q : abs_dy_q;
    minor_len  = x_major_q ? abs_dy_q : abs_dx_q;
    err_sum    = err_q + {1'b0, minor_len};
    take_minor = (err_sum >= {1'b0, major_len});
    err_d      = take_minor ? err_sum - {1'b0, major_len} : err_sum;
    mid_x      = cur_x_q;
    mid_y      = cur_y_q;
    if (take_minor) begin
      if (x_major_q) begin
        mid_y = step_coord(cur_y_q, sign_y_q);
      end else begin
        mid_x = step_coord(cur_x_q, sign_x_q);
      end
    end
    major_pos = x_major_q ? mid_x : mid_y;
    cur_x_d   = x_major_q ? step_coord(mid_x, sign_x_q) : mid_x;
    cur_y_d   = x_major_q ? mid_y : step_coord(mid_y, sign_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd.is_start) begin
      cur_x_q   <= cmd.x;
      cur_y_q   <= cmd.y;
      abs_dx_q  <= cmd.abs_dx;
      abs_dy_q  <= cmd.abs_dy;
      sign_x_q  <= cmd.sign_x;
      sign_y_q  <= cmd.sign_y;
      x_major_q <= cmd.x_major;
      err_q     <= cmd.err;
      pattern_q <= cmd.pattern;
      color_q   <= cmd.color;
    end else if (do_step) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pix_o.pixel_x     <= mid_x;
      pix_o.pixel_y     <= mid_y;
      pix_o.plot        <= pattern_q[major_pos[SelBits-1:0]];
      pix_o.pixel_color <= color_q;
      pix_o.last        <= cmd.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign pix_o.valid = out_valid_q;

endmodule

// ===== rtl/core/stippled_line_stepper_unit.sv =====
// Top level of the stippled line stepper: front, command queue and back.
//
// Stippled Bresenham line stepper. A request with mode start loads both
// endpoints, the 8-bit dash pattern and the color index and produces no
// pixel; each following request with mode step produces exactly one pixel
// (column, row, plot bit, color, last flag) until the pixel marked last has
// been issued. A step while no line is active is dropped without a pixel, and
// a start while a line is active abandons it. A line has (major length + 1)
// pixels; a zero-length line gives one pixel marked last. The plot bit is the
// pattern bit picked by the major coordinate modulo 8. The front half does
// the endpoint setup and the pixel count and drops idle steps; a two-entry
// command queue separates it from the back half, which updates the error term
// and coordinates and owns the pixel output register. Throughput is one
// request per clock, sustained while the pixel sink keeps ready high; it is
// set by the back half's combinational error add, compare and subtract. An
// accepted step is written into the queue, popped by the back half once its
// output register is free, and held there as the pixel until the sink takes it.
// Ready on the request side depends only on queue fullness, never combinationally
// on the pixel sink. Queue storage is not reset; its count is, so no clearing pass.
`include "stippled_line_stepper_unit_defines.svh"

module stippled_line_stepper_unit #(
  parameter int unsigned COORD_BITS = slsu_pkg::COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slsu_in_if.sink    req_i,
  slsu_out_if.source pix_o
);

  // command word: is_start, last, x, y, abs_dx, abs_dy, two signs, x_major,
  // error seed, pattern and color
  localparam int unsigned CmdWidth = 2 + 4 * COORD_BITS + 2 * 2 + 1 + (COORD_BITS + 1)
                                     + slsu_pkg::PATTERN_LEN + slsu_pkg::COLOR_BITS;

  logic                 push, pop;
  logic [CmdWidth-1:0]  cmd_in, cmd_out;
  slsu_pkg::q_status_t  q_stat;
  slsu_pkg::fe_status_t fe_stat;

  slsu_front #(
    .CoordBits (COORD_BITS),
    .CmdWidth  (CmdWidth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .cmd_o    (cmd_in),
    .status_o (fe_stat)
  );

  slsu_queue #(
    .Width (CmdWidth),
    .Depth (slsu_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (cmd_in),
    .pop_i    (pop),
    .data_o   (cmd_out),
    .status_o (q_stat)
  );

  slsu_back #(
    .CoordBits (COORD_BITS),
    .CmdWidth  (CmdWidth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_out),
    .q_empty_i (q_stat.empty),
    .pop_o     (pop),
    .pix_o     (pix_o)
  );

  // queue can never be full and empty at once
  `SLSU_ASSERT_ALWAYS(a_queue_sane, clk_i, !(q_stat.full && q_stat.empty), "queue full and empty")
  // requests are held off exactly when the queue is full
  `SLSU_ASSERT_RST(a_ready_full, clk_i, rst_ni, req_i.ready == !q_stat.full, "ready mismatch")
  // a line only ends on an accepted step
  `SLSU_ASSERT_RST(a_line_end, clk_i, rst_ni, $fell(fe_stat.busy) |-> $past(fe_stat.step_push), "line ended without step")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the stippled line stepper: lines, steps, restarts and stalls.
module tb_top;

  // No request or pixel moving for this many cycles means the block hung.
  localparam int unsigned StallLimit = 2000;
  // The pixel sink holds off this long once, so the command queue fills up.
  localparam int unsigned HoldOffCycles = 300;
  // Spare wait after the last predicted pixel has come out.
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    slsu_pkg::mode_e mode;
    logic [9:0]      sx;
    logic [9:0]      sy;
    logic [9:0]      ex;
    logic [9:0]      ey;
    logic [7:0]      pattern;
    logic [3:0]      color;
  } line_req_t;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic       plot;
    logic [3:0] color;
    logic       last;
  } pixel_t;

  logic clk;
  logic rst_n;

  slsu_in_if  req_if ();
  slsu_out_if pix_if ();

  stippled_line_stepper_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .pix_o  (pix_if)
  );

  // Pixels predicted for accepted steps, oldest first.
  pixel_t      pending_px[$];
  int unsigned mismatches;
  int unsigned pixels_seen;
  int unsigned lines_started;
  int unsigned live_items;    // requests the block acts on (idle steps not counted)
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_left;     // pixel sink hold-off, counted down by the sink
  int unsigned quiet_cycles;

  // Line state as the rasterizer should hold it.
  logic [9:0]      pos_x, pos_y;
  logic [10:0]     err_acc;
  logic [9:0]      span_x, span_y;
  slsu_pkg::sign_e dir_x, dir_y;
  logic            along_x;   // x is the major axis
  logic [10:0]     px_left;
  logic [7:0]      dash;
  logic [3:0]      ink;
  logic            drawing;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [9:0] nudge(input logic [9:0] v, input slsu_pkg::sign_e dir);
    case (dir)
      slsu_pkg::SignPlus:  return v + 10'd1;
      slsu_pkg::SignMinus: return v - 10'd1;
      default:             return v;
    endcase
  endfunction

  // Update the line state for one accepted request; a live step queues its pixel.
  function automatic void rasterize_request(input line_req_t r);
    logic [9:0] major_len, minor_len, major_pos;
    pixel_t     px;
    if (r.mode == slsu_pkg::ModeStart) begin
      span_x  = (r.ex > r.sx) ? r.ex - r.sx : r.sx - r.ex;
      span_y  = (r.ey > r.sy) ? r.ey - r.sy : r.sy - r.ey;
      dir_x   = (r.ex > r.sx) ? slsu_pkg::SignPlus :
                (r.ex < r.sx) ? slsu_pkg::SignMinus : slsu_pkg::SignNone;
      dir_y   = (r.ey > r.sy) ? slsu_pkg::SignPlus :
                (r.ey < r.sy) ? slsu_pkg::SignMinus : slsu_pkg::SignNone;
      pos_x   = r.sx;
      pos_y   = r.sy;
      along_x = (span_x >= span_y);
      major_len = along_x ? span_x : span_y;
      err_acc = {2'b00, major_len[9:1]};
      px_left = {1'b0, major_len} + 11'd1;
      dash    = r.pattern;
      ink     = r.color;
      drawing = 1'b1;
      lines_started++;
      live_items++;
      return;
    end
    if (!drawing) return;   // step with no line: dropped
    live_items++;
    major_len = along_x ? span_x : span_y;
    minor_len = along_x ? span_y : span_x;
    // Minor error moves first, so the minor axis can run past the endpoint.
    err_acc = err_acc + {1'b0, minor_len};
    if (err_acc >= {1'b0, major_len}) begin
      err_acc = err_acc - {1'b0, major_len};
      if (along_x) pos_y = nudge(pos_y, dir_y);
      else         pos_x = nudge(pos_x, dir_x);
    end
    major_pos = along_x ? pos_x : pos_y;
    px_left   = px_left - 11'd1;
    px.x      = pos_x;
    px.y      = pos_y;
    px.plot   = dash[major_pos[2:0]];
    px.color  = ink;
    px.last   = (px_left == 11'd0);
    pending_px.push_back(px);
    if (along_x) pos_x = nudge(pos_x, dir_x);
    else         pos_y = nudge(pos_y, dir_y);
    if (px.last) drawing = 1'b0;
  endfunction

  // Request with every field random, start or step.
  function automatic line_req_t random_request();
    line_req_t r;
    r.mode    = slsu_pkg::mode_e'($urandom_range(1));
    r.sx      = 10'($urandom());
    r.sy      = 10'($urandom());
    r.ex      = 10'($urandom());
    r.ey      = 10'($urandom());
    r.pattern = 8'($urandom());
    r.color   = 4'($urandom());
    return r;
  endfunction

  // Offer one request after a random gap and hold it until the block takes it.
  task automatic send_request(input line_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.start_x     <= r.sx;
    req_if.start_y     <= r.sy;
    req_if.end_x       <= r.ex;
    req_if.end_y       <= r.ey;
    req_if.stipple     <= r.pattern;
    req_if.color_index <= r.color;
    do @(posedge clk); while (!req_if.ready);
    rasterize_request(r);
  endtask

  task automatic send_start(input logic [9:0] sx, sy, ex, ey,
                            input logic [7:0] pattern, input logic [3:0] color);
    line_req_t r;
    r = '{slsu_pkg::ModeStart, sx, sy, ex, ey, pattern, color};
    send_request(r);
  endtask

  // Steps carry random endpoint fields, which the block must ignore.
  task automatic send_steps(input int unsigned n);
    line_req_t r;
    repeat (n) begin
      r = random_request();
      r.mode = slsu_pkg::ModeStep;
      send_request(r);
    end
  endtask

  // Stop offering, then wait until every predicted pixel has come out.
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [9:0] near_coord(input logic [9:0] c, input int reach);
    int v;
    v = int'(c) + int'($urandom_range(2 * reach)) - reach;
    if (v < 0)    v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  task automatic test_directed();
    send_steps(1);                                     // step before any line
    send_start(10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'hFF, 4'd15);
    send_steps(2);                                     // zero length, then idle step
    send_start(10'd0, 10'd0, 10'd3, 10'd0, 8'hA5, 4'd0);
    send_steps(4);                                     // flat, x major, plus
    send_start(10'd6, 10'd5, 10'd4, 10'd0, 8'h3C, 4'd9);
    send_steps(6);                                     // steep, y major, both minus
    send_start(10'd0, 10'd0, 10'd1023, 10'd1023, 8'h0F, 4'd5);
    send_steps(2);                                     // abandoned by the next start
    send_start(10'd0, 10'd1022, 10'd1, 10'd1023, 8'h81, 4'd10);
    send_steps(2);                                     // minor overshoot wraps row to 0
    wait_drained();
  endtask

  // Mostly short lines walked to the end, some long ones cut short, some noise.
  task automatic test_random_lines(input int unsigned n_live,
                                   input int unsigned src_pct, snk_pct);
    int unsigned goal, kind;
    logic [9:0]  sx, sy;
    line_req_t   r;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal = live_items + n_live;
    while (live_items < goal) begin
      kind = $urandom_range(99);
      sx = 10'($urandom_range(1023));
      sy = 10'($urandom_range(1023));
      if (kind < 65) begin
        send_start(sx, sy, near_coord(sx, 12), near_coord(sy, 12),
                   8'($urandom()), 4'($urandom()));
        do send_steps(1); while (drawing);
        if ($urandom_range(4) == 0) send_steps($urandom_range(1, 2));
      end else if (kind < 82) begin
        send_start(sx, sy, 10'($urandom()), 10'($urandom()),
                   8'($urandom()), 4'($urandom()));
        send_steps($urandom_range(1, 24));
      end else begin
        repeat (6) begin
          r = random_request();
          send_request(r);
        end
      end
    end
    wait_drained();
  endtask

  // Sink holds off while steps keep coming, so the queue fills and stalls requests.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_start(10'd0, 10'd0, 10'd200, 10'd50, 8'h5A, 4'd3);
    hold_left = HoldOffCycles;
    send_steps(40);
    wait_drained();
  endtask

  // Pixel sink: random ready, or held low during a hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        pix_if.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each pixel that leaves the block with the oldest prediction.
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (pending_px.size() == 0) begin
        mismatches++;
        $display("%0t: pixel with none expected, actual x=%0d y=%0d", $time,
                 pix_if.pixel_x, pix_if.pixel_y);
      end else begin
        want = pending_px.pop_front();
        pixels_seen++;
        check_field("pixel_x", want.x, pix_if.pixel_x);
        check_field("pixel_y", want.y, pix_if.pixel_y);
        check_field("plot", want.plot, pix_if.plot);
        check_field("pixel_color", want.color, pix_if.pixel_color);
        check_field("last", want.last, pix_if.last);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = slsu_pkg::ModeStart;
    req_if.start_x     = '0;
    req_if.start_y     = '0;
    req_if.end_x       = '0;
    req_if.end_y       = '0;
    req_if.stipple     = '0;
    req_if.color_index = '0;
    pix_if.ready       = 1'b0;
    mismatches    = 0;
    pixels_seen   = 0;
    lines_started = 0;
    live_items    = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 32;
    snk_idle_pct  = 66;
    // Clean state: no line, nothing waiting.
    drawing = 1'b0;
    pos_x = '0; pos_y = '0; err_acc = '0; span_x = '0; span_y = '0;
    dir_x = slsu_pkg::SignNone; dir_y = slsu_pkg::SignNone; along_x = 1'b0; px_left = '0;
    dash = '0; ink = '0;

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_lines(160, 32, 66);
    test_random_lines(160, 66, 32);
    test_random_lines(160, 0, 0);
    test_backpressure();

    $display("Run covered %0d lines and %0d checked pixels over %0d live requests,",
             lines_started, pixels_seen, live_items);
    $display("with restarts, idle steps, wrap-around and a full-queue stall.");
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0t: %0d mismatches, %0d pixels never came", $time, mismatches,
               pending_px.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/slsu_pkg.sv
rtl/core/slsu_ifs.sv
rtl/core/slsu_queue.sv
rtl/core/slsu_front.sv
rtl/core/slsu_back.sv
rtl/core/stippled_line_stepper_unit.sv
sim/tb_top.sv
